### rtl/esm_pkg.sv
// Shared types and constants for the encoder speed meter.
package esm_pkg;

	localparam int AVG_DEPTH_DEF = 7;
	localparam int TIME_BITS_DEF = 32;
	localparam int CFG_IDX_W     = 4;

	localparam logic [7:0]  LOCKOUT_RST = 8'd3;
	localparam logic [15:0] INTERVAL_RST = 16'd16;
	localparam logic [31:0] RPP_RST     = 32'd1920000;
	localparam logic [23:0] KPR_RST     = 24'd1043608;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOCKOUT  = 4'd0,
		CFG_INTERVAL = 4'd1,
		CFG_RPP      = 4'd2,
		CFG_KPR      = 4'd3
	} cfg_idx_t;

	// one finished window handed from front to back
	typedef struct packed {
		logic [15:0] window_pulses;
		logic [31:0] pulse_total;
	} esm_req_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} esm_qstat_t;

endpackage

### rtl/esm_front.sv
// Tick front end: edge lockout, window count and update detection.
module esm_front #(
	parameter int TIME_BITS = esm_pkg::TIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_valid,
	output logic              tick_stall,
	input  logic              edge_seen,
	input  logic [7:0]        lockout_ms,
	input  logic [15:0]       interval_ms,
	input  esm_pkg::esm_qstat_t q_stat,
	output logic              push,
	output esm_pkg::esm_req_t push_req
);
	import esm_pkg::*;

	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] last_acc_q;
	logic [TIME_BITS-1:0] last_upd_q;
	logic [15:0]          win_q;
	logic [31:0]          total_q;

	logic                 take;
	logic                 edge_ok;
	logic                 upd;
	logic [15:0]          win_next;
	logic [31:0]          total_next;

	assign tick_stall = q_stat.full;
	assign take       = tick_valid && !q_stat.full;
	assign edge_ok    = edge_seen && ((now_q - last_acc_q) > TIME_BITS'(lockout_ms));
	assign win_next   = (edge_ok && (win_q != 16'hFFFF)) ? win_q + 16'd1 : win_q;
	assign upd        = (now_q - last_upd_q) >= TIME_BITS'(interval_ms);
	assign total_next = total_q + {16'd0, win_next};

	assign push                   = take && upd;
	assign push_req.window_pulses = win_next;
	assign push_req.pulse_total   = total_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q      <= '0;
			last_acc_q <= '0;
			last_upd_q <= '0;
			win_q      <= '0;
			total_q    <= '0;
		end else if (take) begin
			now_q <= now_q + TIME_BITS'(1);
			if (edge_ok) begin
				last_acc_q <= now_q;
			end
			if (upd) begin
				win_q      <= '0;
				total_q    <= total_next;
				last_upd_q <= now_q;
			end else begin
				win_q <= win_next;
			end
		end
	end

endmodule

### rtl/esm_queue.sv
// Two-entry request queue between front and back.
module esm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  esm_pkg::esm_req_t   push_req,
	input  logic                pop,
	output esm_pkg::esm_req_t   pop_req,
	output esm_pkg::esm_qstat_t q_stat
);
	import esm_pkg::*;

	esm_req_t   slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign pop_req          = slot_q[rd_ptr_q];
	assign q_stat.full      = count_q[1];
	assign q_stat.not_empty = count_q != 2'd0;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### rtl/esm_back.sv
// Back end: RPM, ring average, divide by depth, km/h and result register.
module esm_back #(
	parameter int AVG_DEPTH = esm_pkg::AVG_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  esm_pkg::esm_qstat_t q_stat,
	input  esm_pkg::esm_req_t   pop_req,
	output logic                pop,
	input  logic [31:0]         rpm_per_pulse,
	input  logic [23:0]         kph_per_rpm,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [15:0]         window_pulses,
	output logic [31:0]         rpm_now,
	output logic [31:0]         rpm_mean,
	output logic [15:0]         speed_kph,
	output logic [31:0]         mean_kph,
	output logic [31:0]         pulse_total
);
	import esm_pkg::*;

	localparam int SLOT_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int SUM_W     = 32 + $clog2(AVG_DEPTH);
	localparam int DIV_SHIFT = SUM_W + $clog2(AVG_DEPTH);
	// ceil(2^DIV_SHIFT / AVG_DEPTH), exact floor division for any ring sum
	localparam logic [63:0] RECIP =
		((64'd1 << DIV_SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH);
	localparam logic [31:0] RECIP_LO = RECIP[31:0];
	localparam logic [7:0]  RECIP_HI = RECIP[39:32];
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(AVG_DEPTH - 1);

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_RING,
		B_DIV,
		B_DIVH,
		B_KPH,
		B_OUT
	} bstate_t;

	bstate_t              state_q;
	logic [15:0]          win_q;
	logic [31:0]          total_q;
	logic [47:0]          rpm_prod_s1;
	logic [31:0]          rpm_q;
	logic [55:0]          spd_prod_s2;
	logic [55:0]          mkph_prod_s3;
	logic [SUM_W-1:0]     sum_q;
	logic [63:0]          div_lo_q;
	logic [40:0]          div_mid_q;
	logic [31:0]          mean_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [AVG_DEPTH-1:0] ring_vld_q;
	logic [31:0]          ring_mem [AVG_DEPTH];
	logic [31:0]          ring_rd_q;

	logic                 out_valid_q;
	logic [15:0]          window_pulses_q;
	logic [31:0]          rpm_now_q;
	logic [31:0]          rpm_mean_q;
	logic [15:0]          speed_kph_q;
	logic [31:0]          mean_kph_q;
	logic [31:0]          pulse_total_q;

	logic [31:0]          rpm_sat;
	logic [31:0]          old_rpm;
	logic [SUM_W-1:0]     sum_new;
	logic [39:0]          sum_ext;
	logic [47:0]          div_top;
	logic [31:0]          mean_next;
	logic                 ring_we;
	logic                 out_load;

	assign rpm_sat   = (|rpm_prod_s1[47:32]) ? 32'hFFFF_FFFF : rpm_prod_s1[31:0];
	assign old_rpm   = ring_vld_q[slot_q] ? ring_rd_q : 32'd0;
	assign sum_new   = sum_q - SUM_W'(old_rpm) + SUM_W'(rpm_sat);
	assign sum_ext   = 40'(sum_q);
	assign div_top   = 48'(div_mid_q) + 48'(div_lo_q[63:32]) +
		{16'(sum_ext[39:32]) * 16'(RECIP_HI), 32'd0};
	assign mean_next = 32'(div_top >> (DIV_SHIFT - 32));
	assign ring_we   = state_q == B_RING;
	assign out_load  = (state_q == B_OUT) && (!out_valid_q || !out_stall);
	assign pop       = (state_q == B_IDLE) && q_stat.not_empty;

	assign out_valid     = out_valid_q;
	assign window_pulses = window_pulses_q;
	assign rpm_now       = rpm_now_q;
	assign rpm_mean      = rpm_mean_q;
	assign speed_kph     = speed_kph_q;
	assign mean_kph      = mean_kph_q;
	assign pulse_total   = pulse_total_q;

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[slot_q] <= rpm_sat;
		end
		ring_rd_q <= ring_mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= B_IDLE;
			win_q           <= '0;
			total_q         <= '0;
			rpm_prod_s1     <= '0;
			rpm_q           <= '0;
			spd_prod_s2     <= '0;
			mkph_prod_s3    <= '0;
			sum_q           <= '0;
			div_lo_q        <= '0;
			div_mid_q       <= '0;
			mean_q          <= '0;
			slot_q          <= '0;
			ring_vld_q      <= '0;
			out_valid_q     <= 1'b0;
			window_pulses_q <= '0;
			rpm_now_q       <= '0;
			rpm_mean_q      <= '0;
			speed_kph_q     <= '0;
			mean_kph_q      <= '0;
			pulse_total_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						win_q   <= pop_req.window_pulses;
						total_q <= pop_req.pulse_total;
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					rpm_prod_s1 <= 48'(win_q) * 48'(rpm_per_pulse);
					state_q     <= B_RING;
				end
				B_RING: begin
					rpm_q              <= rpm_sat;
					sum_q              <= sum_new;
					ring_vld_q[slot_q] <= 1'b1;
					slot_q             <= (slot_q == LAST_SLOT) ? '0 : slot_q + SLOT_W'(1);
					state_q            <= B_DIV;
				end
				B_DIV: begin
					spd_prod_s2 <= 56'(rpm_q) * 56'(kph_per_rpm);
					div_lo_q    <= 64'(sum_ext[31:0]) * 64'(RECIP_LO);
					div_mid_q   <= 41'(sum_ext[31:0]) * 41'(RECIP_HI) +
						41'(sum_ext[39:32]) * 41'(RECIP_LO);
					state_q     <= B_DIVH;
				end
				B_DIVH: begin
					mean_q  <= mean_next;
					state_q <= B_KPH;
				end
				B_KPH: begin
					mkph_prod_s3 <= 56'(mean_q) * 56'(kph_per_rpm);
					state_q      <= B_OUT;
				end
				B_OUT: begin
					if (out_load) begin
						window_pulses_q <= win_q;
						rpm_now_q       <= rpm_q;
						rpm_mean_q      <= mean_q;
						speed_kph_q     <= spd_prod_s2[55:40];
						mean_kph_q      <= mkph_prod_s3[55:24];
						pulse_total_q   <= total_q;
						state_q         <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/encoder_speed_meter_core.sv
// Encoder speed meter top level: config registers, front, queue and back.
// Each request is one millisecond tick. A tick that closes no window is taken and gives
// no result; ticks are taken every cycle while the two-entry window queue has
// room. A tick that closes a window queues one request; the back end handles each
// window in order: pop, RPM multiply, ring update, two reciprocal-multiply steps for the
// divide by AVG_DEPTH, km/h multiply and output load. The result then waits in the output
// register while the back end starts the next window; a stalled result holds the back
// end and, once the queue fills, the input. The averaging ring reads as zero after reset
// through per-entry valid bits; no clearing pass is needed.
module encoder_speed_meter_core #(
	parameter int AVG_DEPTH = esm_pkg::AVG_DEPTH_DEF,
	parameter int TIME_BITS = esm_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          edge_seen,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [15:0]                   window_pulses,
	output logic [31:0]                   rpm_now,
	output logic [31:0]                   rpm_mean,
	output logic [15:0]                   speed_kph,
	output logic [31:0]                   mean_kph,
	output logic [31:0]                   pulse_total,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [esm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import esm_pkg::*;

	logic [7:0]  lockout_q;
	logic [15:0] interval_q;
	logic [31:0] rpp_q;
	logic [23:0] kpr_q;

	esm_qstat_t  q_stat;
	esm_req_t    push_req;
	esm_req_t    pop_req;
	logic        push;
	logic        pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q  <= LOCKOUT_RST;
			interval_q <= INTERVAL_RST;
			rpp_q      <= RPP_RST;
			kpr_q      <= KPR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_LOCKOUT:  lockout_q  <= cfg_data[7:0];
				CFG_INTERVAL: interval_q <= cfg_data[15:0];
				CFG_RPP:      rpp_q      <= cfg_data;
				CFG_KPR:      kpr_q      <= cfg_data[23:0];
				default: begin
				end
			endcase
		end
	end

	esm_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (in_valid),
		.tick_stall (in_stall),
		.edge_seen  (edge_seen),
		.lockout_ms (lockout_q),
		.interval_ms(interval_q),
		.q_stat     (q_stat),
		.push       (push),
		.push_req   (push_req)
	);

	esm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_req(push_req),
		.pop     (pop),
		.pop_req (pop_req),
		.q_stat  (q_stat)
	);

	esm_back #(
		.AVG_DEPTH(AVG_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.pop_req      (pop_req),
		.pop          (pop),
		.rpm_per_pulse(rpp_q),
		.kph_per_rpm  (kpr_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.window_pulses(window_pulses),
		.rpm_now      (rpm_now),
		.rpm_mean     (rpm_mean),
		.speed_kph    (speed_kph),
		.mean_kph     (mean_kph),
		.pulse_total  (pulse_total)
	);

endmodule

### rtl/esm_checker.sv
// Port-level checks for the encoder speed meter, bound to the top level.
module esm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] window_pulses,
	input logic [31:0] rpm_now,
	input logic [31:0] rpm_mean,
	input logic [15:0] speed_kph,
	input logic [31:0] mean_kph,
	input logic [31:0] pulse_total,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its fields
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(window_pulses) && $stable(rpm_now) &&
			$stable(rpm_mean) && $stable(speed_kph) && $stable(mean_kph) &&
			$stable(pulse_total))
		else $error("result changed while stalled");

	// empty window gives zero speed
	a_zero_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (window_pulses == 16'd0) |-> (rpm_now == 32'd0) && (speed_kph == 16'd0))
		else $error("nonzero speed from empty window");

	// an rpm below 2^16 gives zero speed
	a_speed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (rpm_now[31:16] == 16'd0) |-> (speed_kph == 16'd0))
		else $error("speed_kph too large for rpm_now");

	// config writes are never held off
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind encoder_speed_meter_core esm_checker u_esm_checker (.*);

### verif/encoder_speed_meter_checker.sv
// Checker for the encoder speed meter: predicts each window report and compares the outputs.
`timescale 1ns / 1ps
module encoder_speed_meter_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          edge_seen,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [15:0]                   window_pulses,
	input  logic [31:0]                   rpm_now,
	input  logic [31:0]                   rpm_mean,
	input  logic [15:0]                   speed_kph,
	input  logic [31:0]                   mean_kph,
	input  logic [31:0]                   pulse_total,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [esm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	output int                            mismatches,
	output int                            reports_pending,
	output int                            reports_seen
);
	import esm_pkg::*;

	localparam int RING_DEPTH = AVG_DEPTH_DEF;

	typedef struct packed {
		logic [15:0] pulses;
		logic [31:0] rpm;
		logic [31:0] rpm_avg;
		logic [15:0] kph;
		logic [31:0] kph_avg;
		logic [31:0] total;
	} speed_report_t;

	logic [7:0]    lockout_ms;
	logic [15:0]   interval_ms;
	logic [31:0]   rpm_per_pulse;
	logic [23:0]   kph_per_rpm;
	logic [31:0]   now_ms;
	logic [31:0]   last_edge_ms;
	logic [31:0]   last_report_ms;
	logic [15:0]   window_count;
	logic [31:0]   total_count;
	logic [31:0]   rpm_history [RING_DEPTH];
	int            history_slot;
	logic [34:0]   history_sum;
	int            fail_count;
	int            seen_count;
	speed_report_t expected_reports[$];

	task automatic count_one_ms(input logic edge_bit);
		logic [31:0]   since_edge;
		logic [31:0]   since_report;
		logic [63:0]   rpm_wide;
		logic [63:0]   kph_wide;
		logic [63:0]   kph_avg_wide;
		logic [31:0]   rpm;
		logic [31:0]   rpm_avg;
		speed_report_t rep;
		since_edge = now_ms - last_edge_ms;
		if (edge_bit && since_edge > {24'd0, lockout_ms}) begin
			if (window_count != 16'hFFFF)
				window_count = window_count + 16'd1;
			last_edge_ms = now_ms;
		end
		since_report = now_ms - last_report_ms;
		if (since_report >= {16'd0, interval_ms}) begin
			rpm_wide = {48'd0, window_count} * {32'd0, rpm_per_pulse};
			rpm = (rpm_wide > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : rpm_wide[31:0];
			total_count = total_count + {16'd0, window_count};
			history_sum = history_sum - {3'd0, rpm_history[history_slot]} + {3'd0, rpm};
			rpm_history[history_slot] = rpm;
			history_slot = (history_slot == RING_DEPTH - 1) ? 0 : history_slot + 1;
			rpm_avg = 32'(history_sum / RING_DEPTH);
			kph_wide = ({32'd0, rpm} * {40'd0, kph_per_rpm}) >> 40;
			kph_avg_wide = ({32'd0, rpm_avg} * {40'd0, kph_per_rpm}) >> 24;
			rep.pulses = window_count;
			rep.rpm = rpm;
			rep.rpm_avg = rpm_avg;
			rep.kph = (kph_wide > 64'h0000_0000_0000_FFFF) ? 16'hFFFF : kph_wide[15:0];
			rep.kph_avg = kph_avg_wide[31:0];
			rep.total = total_count;
			expected_reports.push_back(rep);
			last_report_ms = now_ms;
			window_count = 16'd0;
		end
		now_ms = now_ms + 32'd1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		speed_report_t want;
		speed_report_t got;
		if (!arst_n) begin
			lockout_ms = LOCKOUT_RST;
			interval_ms = INTERVAL_RST;
			rpm_per_pulse = RPP_RST;
			kph_per_rpm = KPR_RST;
			now_ms = '0;
			last_edge_ms = '0;
			last_report_ms = '0;
			window_count = '0;
			total_count = '0;
			for (int i = 0; i < RING_DEPTH; i++)
				rpm_history[i] = '0;
			history_slot = 0;
			history_sum = '0;
			fail_count = 0;
			seen_count = 0;
			expected_reports.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_LOCKOUT:  lockout_ms = cfg_data[7:0];
					CFG_INTERVAL: interval_ms = cfg_data[15:0];
					CFG_RPP:      rpm_per_pulse = cfg_data;
					CFG_KPR:      kph_per_rpm = cfg_data[23:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				count_one_ms(edge_seen);
			if (out_valid && !out_stall) begin
				got = '{window_pulses, rpm_now, rpm_mean, speed_kph, mean_kph, pulse_total};
				if (expected_reports.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: report with none outstanding: pulses %0d rpm %h total %0d",
							$realtime, got.pulses, got.rpm, got.total);
				end else begin
					want = expected_reports.pop_front();
					seen_count++;
					if (got.pulses !== want.pulses || got.rpm !== want.rpm ||
						got.rpm_avg !== want.rpm_avg || got.kph !== want.kph ||
						got.kph_avg !== want.kph_avg || got.total !== want.total) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: report %0d mismatch", $realtime, seen_count);
							$display("  exp pulses %h rpm %h avg %h kph %h kph_avg %h total %h",
								want.pulses, want.rpm, want.rpm_avg, want.kph, want.kph_avg,
								want.total);
							$display("  got pulses %h rpm %h avg %h kph %h kph_avg %h total %h",
								got.pulses, got.rpm, got.rpm_avg, got.kph, got.kph_avg,
								got.total);
						end
					end
				end
			end
		end
		mismatches <= fail_count;
		reports_pending <= expected_reports.size();
		reports_seen <= seen_count;
	end

endmodule

### verif/encoder_speed_meter_core_tb.sv
// Testbench top for the encoder speed meter: tick stimulus, register phases and verdict.
`timescale 1ns / 1ps
module encoder_speed_meter_core_tb;
	import esm_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd11;
	localparam int SETTLE_CYCLES = 120;
	localparam int RANDOM_PHASES = 12;
	localparam int TICKS_PER_PHASE = 110;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 edge_seen = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [15:0]          window_pulses;
	logic [31:0]          rpm_now;
	logic [31:0]          rpm_mean;
	logic [15:0]          speed_kph;
	logic [31:0]          mean_kph;
	logic [31:0]          pulse_total;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_data = '0;
	int                   mismatches;
	int                   reports_pending;
	int                   reports_seen;
	int                   send_idle_pct = 0;
	int                   recv_stall_pct = 0;
	int                   ticks_sent = 0;
	int                   reg_writes = 0;
	int                   settings_used = 1;

	encoder_speed_meter_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .edge_seen(edge_seen),
		.out_valid(out_valid), .out_stall(out_stall),
		.window_pulses(window_pulses), .rpm_now(rpm_now), .rpm_mean(rpm_mean),
		.speed_kph(speed_kph), .mean_kph(mean_kph), .pulse_total(pulse_total),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	encoder_speed_meter_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .edge_seen(edge_seen),
		.out_valid(out_valid), .out_stall(out_stall),
		.window_pulses(window_pulses), .rpm_now(rpm_now), .rpm_mean(rpm_mean),
		.speed_kph(speed_kph), .mean_kph(mean_kph), .pulse_total(pulse_total),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches), .reports_pending(reports_pending),
		.reports_seen(reports_seen)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic set_idling(input int mode);
		case (mode)
			1: begin
				send_idle_pct = 61;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 61;
			end
			3: begin
				send_idle_pct = 31;
				recv_stall_pct = 31;
			end
			default: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
		endcase
	endtask

	task automatic send_tick(input logic edge_bit);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		edge_seen <= edge_bit;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		ticks_sent++;
	endtask

	task automatic drain_requests();
		in_valid <= 1'b0;
		@(posedge clk);
		while (reports_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		reg_writes++;
	endtask

	task automatic program_meter(input logic [31:0] lockout, input logic [31:0] interval,
		input logic [31:0] rpp, input logic [31:0] kpr, input bit spare);
		write_reg(CFG_LOCKOUT, lockout);
		write_reg(CFG_INTERVAL, interval);
		write_reg(CFG_RPP, rpp);
		write_reg(CFG_KPR, kpr);
		if (spare)
			write_reg(CFG_SPARE, $urandom);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	initial begin
		logic [31:0] lockout_val;
		logic [31:0] interval_val;
		logic [31:0] rpp_val;
		logic [31:0] kpr_val;
		int          edge_pct;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset values: the window closes on the seventeenth tick
		repeat (17) send_tick(1'b1);
		drain_requests();
		// upper data bits dropped, zero lockout, report every tick, top scales
		program_meter(32'hFFFF_FF00, 32'hABCD_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		drain_requests();
		// two pulses per window saturate the RPM
		program_meter(32'd0, 32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		repeat (3) send_tick(1'b1);
		drain_requests();
		program_meter(32'd255, 32'hFFFF, 32'd0, 32'd0, 1'b0);
		repeat (3) send_tick(1'b1);
		drain_requests();
		program_meter(32'd255, 32'd1, RPP_RST, KPR_RST, 1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		drain_requests();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(3))
				0: lockout_val = 32'd0;
				1: lockout_val = 32'd255;
				default: lockout_val = $urandom_range(6);
			endcase
			if ($urandom_range(7) == 0)
				interval_val = $urandom_range(40, 11);
			else
				interval_val = $urandom_range(10);
			case ($urandom_range(4))
				0: rpp_val = 32'd0;
				1: rpp_val = 32'hFFFF_FFFF;
				2: rpp_val = RPP_RST;
				default: rpp_val = $urandom;
			endcase
			case ($urandom_range(4))
				0: kpr_val = 32'd0;
				1: kpr_val = 32'h00FF_FFFF;
				2: kpr_val = {8'd0, KPR_RST};
				default: kpr_val = $urandom;
			endcase
			program_meter(($urandom & 32'hFFFF_FF00) | lockout_val,
				($urandom & 32'hFFFF_0000) | interval_val, rpp_val,
				($urandom & 32'hFF00_0000) | kpr_val, $urandom_range(3) == 0);
			set_idling(p % 4);
			edge_pct = $urandom_range(95, 5);
			for (int k = 0; k < TICKS_PER_PHASE; k++) begin
				if (p == 5 && k == TICKS_PER_PHASE / 2)
					drain_requests();
				send_tick($urandom_range(99) < edge_pct);
			end
			drain_requests();
		end

		$display("Run covered %0d millisecond ticks under %0d register settings,",
			ticks_sent, settings_used);
		$display("with %0d register writes and %0d speed reports checked.",
			reg_writes, reports_seen);
		if (mismatches == 0 && reports_pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
